@@ hw/rtl/pfa_pkg.sv @@
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types and constants for the fixed partition allocator: operation
// and register codes, partition count, reset capacities, control structs.
// ----------------------------------------------------------------------------
package pfa_pkg;

    // partitions in use (1 to 4) and the slots that hold size registers
    localparam int NUM_BLOCKS = 4;
    localparam int SLOT_COUNT = 4;

    localparam int IDX_W  = 2;
    localparam int SIZE_W = 16;
    localparam int MODE_W = 2;
    localparam int CFG_IDX_W = 3;

    localparam int S_TDATA_W = 24;  // request_size, free_index, zero fill
    localparam int S_TUSER_W = 2;   // mode
    localparam int M_TDATA_W = 24;  // granted, block_index, block_size, zero fill

    // operation codes carried in s_tuser
    localparam logic [MODE_W-1:0] MODE_ALLOC    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE_ONE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FREE_ALL = 2'd2;

    // fit policy codes
    localparam logic POLICY_BEST_FIT  = 1'b0;
    localparam logic POLICY_FIRST_FIT = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_ZERO_SIZE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_ONE_SIZE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_TWO_SIZE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_THREE_SIZE = 3'd4;

    typedef logic [SIZE_W-1:0] size_t;

    // capacities after reset, slot 0 first
    localparam size_t RESET_SIZE [SLOT_COUNT] = '{16'd100, 16'd50, 16'd30, 16'd120};

    // last partition visited by the scan
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BLOCKS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;       // latch the incoming item, restart the scan
        logic scan_step;  // evaluate one partition
        logic commit;     // update taken bits and load the output register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic new_is_alloc;  // incoming item is an allocate request
        logic scan_last;     // scan is at the last partition
        logic out_free;      // output register can take a result
    } status_t;

endpackage

@@ hw/rtl/pfa_ctrl.sv @@
// ----------------------------------------------------------------------------
// pfa_ctrl
// Sequencer for the allocator: takes an item, steps the partition scan for
// allocate requests, then commits the result once the output register is free.
// ----------------------------------------------------------------------------
module pfa_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  pfa_pkg::status_t status,
    output pfa_pkg::cmd_t    cmd
);
    import pfa_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = status.new_is_alloc ? ST_SCAN : ST_COMMIT;
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (status.scan_last) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/pfa_datapath.sv @@
// ----------------------------------------------------------------------------
// pfa_datapath
// Configuration registers, taken bits, item latch, one-partition-per-cycle
// fit comparator and the output register of the result channel.
// ----------------------------------------------------------------------------
module pfa_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [pfa_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic [pfa_pkg::S_TUSER_W-1:0]     s_tuser,
    input  logic                              cfg_valid,
    input  logic [pfa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pfa_pkg::SIZE_W-1:0]        cfg_data,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pfa_pkg::M_TDATA_W-1:0]     m_tdata,
    input  pfa_pkg::cmd_t                     cmd,
    output pfa_pkg::status_t                  status
);
    import pfa_pkg::*;

    logic                policy_reg;
    size_t               size_reg [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] taken_reg;
    logic [SLOT_COUNT-1:0] taken_next;

    logic [MODE_W-1:0]   mode_reg;
    size_t               req_reg;
    logic [IDX_W-1:0]    fidx_reg;

    logic [IDX_W-1:0]    scan_idx_reg;
    logic                found_reg;
    logic [IDX_W-1:0]    pick_reg;
    size_t               pick_size_reg;

    logic                m_valid_reg;
    logic                granted_reg;
    logic [IDX_W-1:0]    index_reg;
    size_t               bsize_reg;

    logic                granted_next;
    logic [IDX_W-1:0]    index_next;
    size_t               bsize_next;

    size_t               cand_size;
    logic                cand_fits;
    logic                cand_better;
    logic                fidx_live;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg <= POLICY_BEST_FIT;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                size_reg[i] <= RESET_SIZE[i];
            end
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_FIT_POLICY:       policy_reg  <= cfg_data[0];
                REG_BLOCK_ZERO_SIZE:  size_reg[0] <= cfg_data;
                REG_BLOCK_ONE_SIZE:   size_reg[1] <= cfg_data;
                REG_BLOCK_TWO_SIZE:   size_reg[2] <= cfg_data;
                REG_BLOCK_THREE_SIZE: size_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // one partition per scan step
    assign cand_size   = size_reg[scan_idx_reg];
    assign cand_fits   = !taken_reg[scan_idx_reg] && (cand_size >= req_reg);
    assign cand_better = !found_reg
                         || ((policy_reg == POLICY_BEST_FIT) && (cand_size < pick_size_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_idx_reg <= '0;
            found_reg    <= 1'b0;
        end else if (cmd.load) begin
            scan_idx_reg <= '0;
            found_reg    <= 1'b0;
        end else if (cmd.scan_step) begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
            if (cand_fits && cand_better) begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg <= s_tuser[MODE_W-1:0];
            req_reg  <= s_tdata[SIZE_W-1:0];
            fidx_reg <= s_tdata[SIZE_W +: IDX_W];
        end
        if (cmd.scan_step && cand_fits && cand_better) begin
            pick_reg      <= scan_idx_reg;
            pick_size_reg <= cand_size;
        end
    end

    // result and taken update at commit
    assign fidx_live = ({1'b0, fidx_reg} < (IDX_W + 1)'(NUM_BLOCKS));

    always_comb begin
        taken_next   = taken_reg;
        granted_next = 1'b0;
        index_next   = '0;
        bsize_next   = '0;
        case (mode_reg)
            MODE_ALLOC: begin
                if (found_reg) begin
                    taken_next[pick_reg] = 1'b1;
                    granted_next         = 1'b1;
                    index_next           = pick_reg;
                    bsize_next           = pick_size_reg;
                end
            end
            MODE_FREE_ONE: begin
                if (fidx_live) begin
                    taken_next[fidx_reg] = 1'b0;
                    granted_next         = 1'b1;
                    index_next           = fidx_reg;
                end
            end
            MODE_FREE_ALL: begin
                taken_next   = '0;
                granted_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            taken_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.commit) begin
                taken_reg   <= taken_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            granted_reg <= granted_next;
            index_reg   <= index_next;
            bsize_reg   <= bsize_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - 1 - IDX_W - SIZE_W){1'b0}},
                       bsize_reg, index_reg, granted_reg};

    assign status.new_is_alloc = (s_tuser[MODE_W-1:0] == MODE_ALLOC);
    assign status.scan_last    = (scan_idx_reg == LAST_IDX);
    assign status.out_free     = !m_valid_reg || m_tready;

    // a pending result is never overwritten
    a_commit_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_valid_reg || m_tready))
        else $error("commit while output register still holds a result");

    // only allocate requests scan the partitions
    a_scan_alloc_only: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_step |-> (mode_reg == MODE_ALLOC))
        else $error("scan step for a non-allocate item");

    // a granted partition is large enough and was free
    a_grant_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && (mode_reg == MODE_ALLOC) && found_reg)
            |-> ((pick_size_reg >= req_reg) && !taken_reg[pick_reg]))
        else $error("granted partition too small or already taken");

    // an allocation grant leaves that partition taken
    a_grant_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && (mode_reg == MODE_ALLOC) && found_reg) |=> taken_reg[index_reg])
        else $error("granted partition not marked taken");

endmodule

@@ hw/rtl/partition_fit_allocator.sv @@
// An allocate request is compared against one partition per cycle in ST_SCAN,
// over all four partitions, then its result is loaded into the output register
// in ST_COMMIT; free-one and free-all go straight from the transfer to ST_COMMIT.
// A new item is taken only in ST_IDLE, once the last one is committed, and the
// single comparator is shared across the partitions; a held result stalls commit.
// Reset (aresetn low, synchronous): all partitions free, reset capacities, best fit.
// ----------------------------------------------------------------------------
// partition_fit_allocator
// Fixed partition allocator over four partitions with best fit or first fit
// selection, single free and free all, on stream in and out channels.
// ----------------------------------------------------------------------------
module partition_fit_allocator (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [pfa_pkg::S_TDATA_W-1:0] s_tdata,   // request_size, free_index, zero fill
    input  logic [pfa_pkg::S_TUSER_W-1:0] s_tuser,   // mode
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pfa_pkg::M_TDATA_W-1:0] m_tdata,   // granted, block_index, block_size, zero fill
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pfa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pfa_pkg::SIZE_W-1:0]    cfg_data
);
    import pfa_pkg::*;

    cmd_t    cmd;
    status_t status;

    // configuration registers take a write in any cycle
    assign cfg_ready = 1'b1;

    pfa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pfa_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
